// ===== hw/rtl/bdasc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared widths, defaults and character codes for the decimal text formatter.
// ----------------------------------------------------------------------------
package bdasc_pkg;

   localparam int VALUE_W        = 64;
   localparam int VALUE_BITS_DEF = 64;
   localparam int MAX_DIGITS_DEF = 20;

   localparam int CSR_W = 7;
   localparam int CHAR_W = 8;
   localparam int LEN_W = 8;

   localparam logic [CSR_W-1:0]  BUF_CHARS_RESET = 7'd36;
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE       = 8'h00;

endpackage
`default_nettype wire

// ===== hw/rtl/bdasc_dabble.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Shift-add-3 step
// One double-dabble step: corrects every BCD digit and shifts the binary bit in.
// ----------------------------------------------------------------------------
module bdasc_dabble #(
   parameter int VALUE_BITS = bdasc_pkg::VALUE_BITS_DEF,
   parameter int BCD_DIGITS = 20
) (
   input  wire logic [BCD_DIGITS*4-1:0] bcd_cur,
   input  wire logic [VALUE_BITS-1:0]   bin_cur,
   output logic      [BCD_DIGITS*4-1:0] bcd_nxt,
   output logic      [VALUE_BITS-1:0]   bin_nxt
);

   localparam int BCD_W = BCD_DIGITS * 4;

   logic [BCD_W-1:0] bcd_adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_cur[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_cur[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_cur[i*4 +: 4];
         end
      end
   end

   assign bcd_nxt = {bcd_adj[BCD_W-2:0], bin_cur[VALUE_BITS-1]};
   assign bin_nxt = {bin_cur[VALUE_BITS-2:0], 1'b0};

endmodule
`default_nettype wire

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Binary to decimal ASCII
// Converts a signed or unsigned integer into decimal text, one character per beat.
// ----------------------------------------------------------------------------
// A beat on the req channel carries the integer in tdata and the signed flag in
// tuser. The rsp channel returns the text most significant character first,
// with a leading minus for negative signed values, tlast on the final beat.
// If the text plus its terminator does not fit the buffer size held in the
// csr register, a single beat with tdata zero, tuser and tlast set is returned.
// The conversion runs through one shift-add-3 unit, one bit per cycle. An item
// is accepted, converted over all VALUE_BITS bits, trimmed of its leading zero
// digits one at a time, sized against the buffer and then sent one character
// at a time, a leading minus sign first.
// req_tready is high only while the sequencer is idle; the last character may
// still wait in the output register while the next item is taken.
// A stalled receiver holds the output register and pauses the sending of characters.
// Reset empties the output register, returns to idle and sets the buffer
// size to 36.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = bdasc_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = bdasc_pkg::MAX_DIGITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bdasc_pkg::VALUE_W-1:0]    req_tdata,  // value
   input  wire logic                             req_tuser,  // is_signed
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [bdasc_pkg::CHAR_W-1:0]     rsp_tdata,  // char_code
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser,  // overflow_error
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bdasc_pkg::CSR_W-1:0]      csr_data
);

   localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W      = BCD_DIGITS * 4;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int DIG_W      = $clog2(BCD_DIGITS + 1);
   localparam int LEN_W      = bdasc_pkg::LEN_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [VALUE_BITS-1:0]          bin_ff, bin_in;
   logic [BCD_W-1:0]               bcd_ff, bcd_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [DIG_W-1:0]               ndig_ff, ndig_in;
   logic                           neg_ff, neg_in;
   logic                           sign_pend_ff, sign_pend_in;
   logic                           err_ff, err_in;
   logic [bdasc_pkg::CSR_W-1:0]    buf_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bdasc_pkg::CHAR_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_user_ff, rsp_user_in;

   logic [VALUE_BITS-1:0]          req_value;
   logic                           req_neg;
   logic [BCD_W-1:0]               dab_bcd;
   logic [VALUE_BITS-1:0]          dab_bin;
   logic [3:0]                     top_digit;
   logic [LEN_W-1:0]               text_len;
   logic                           err_calc;
   logic                           out_free;
   logic [BCD_W-1:0]               bcd_shift;

   bdasc_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .BCD_DIGITS (BCD_DIGITS)
   ) u_dabble (
      .bcd_cur (bcd_ff),
      .bin_cur (bin_ff),
      .bcd_nxt (dab_bcd),
      .bin_nxt (dab_bin)
   );

   assign req_value = req_tdata[VALUE_BITS-1:0];
   assign req_neg   = req_tuser & req_value[VALUE_BITS-1];
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign bcd_shift = {bcd_ff[BCD_W-5:0], 4'b0000};
   assign text_len  = LEN_W'(ndig_ff) + LEN_W'(neg_ff);
   assign err_calc  = (LEN_W'(ndig_ff) > LEN_W'(MAX_DIGITS)) ||
                      (text_len >= LEN_W'(buf_ff));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      ndig_in      = ndig_ff;
      neg_in       = neg_ff;
      sign_pend_in = sign_pend_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in   = req_neg;
               bin_in   = req_neg ? (~req_value + VALUE_BITS'(1)) : req_value;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = dab_bcd;
            bin_in = dab_bin;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               ndig_in  = DIG_W'(BCD_DIGITS);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((top_digit == 4'd0) && (ndig_ff != DIG_W'(1))) begin
               bcd_in  = bcd_shift;
               ndig_in = ndig_ff - DIG_W'(1);
            end else begin
               err_in       = err_calc;
               sign_pend_in = neg_ff;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_data_in = bdasc_pkg::CHAR_NONE;
                  rsp_last_in = 1'b1;
                  rsp_user_in = 1'b1;
                  state_in    = ST_IDLE;
               end else if (sign_pend_ff) begin
                  rsp_data_in  = bdasc_pkg::CHAR_MINUS;
                  rsp_last_in  = 1'b0;
                  rsp_user_in  = 1'b0;
                  sign_pend_in = 1'b0;
               end else begin
                  rsp_data_in = bdasc_pkg::CHAR_ZERO + {4'b0000, top_digit};
                  rsp_last_in = (ndig_ff == DIG_W'(1));
                  rsp_user_in = 1'b0;
                  bcd_in      = bcd_shift;
                  ndig_in     = ndig_ff - DIG_W'(1);
                  if (ndig_ff == DIG_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ndig_ff      <= '0;
         neg_ff       <= 1'b0;
         sign_pend_ff <= 1'b0;
         err_ff       <= 1'b0;
         buf_ff       <= bdasc_pkg::BUF_CHARS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ndig_ff      <= ndig_in;
         neg_ff       <= neg_in;
         sign_pend_ff <= sign_pend_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            buf_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CONV))
      else $error("accepted beat did not start a conversion");

   a_conv_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (cnt_ff != '0))
      else $error("bit counter empty during conversion");

   a_digits_present: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_EMIT)) |-> (ndig_ff != '0))
      else $error("no digits left while scanning or sending");

   a_error_beat_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && (rsp_tdata == bdasc_pkg::CHAR_NONE)))
      else $error("error beat is not a lone terminating beat");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && rsp_last_in && !err_ff && !sign_pend_ff)
      |=> (state_ff == ST_IDLE))
      else $error("sequencer kept running after the last character");
`endif

endmodule
`default_nettype wire
